### rtl/core/wpsp_pkg.sv
// shared constants for the wav pcm stream parser
package wpsp_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned SAMPLE_W = 32;
   localparam int unsigned CHAN_W = 16;
   localparam int unsigned RATE_W = 32;
   localparam int unsigned BITS_W = 16;
   localparam int unsigned ERR_W = 3;
   localparam int unsigned KIND_W = 2;
   localparam int unsigned IDX_W = 5;
   localparam int unsigned RSP_FIELDS_W = SAMPLE_W + CHAN_W + RATE_W + BITS_W + ERR_W;
   localparam int unsigned RSP_DATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [31:0] ID_RIFF = 32'h4646_4952;
   localparam logic [31:0] ID_FMT = 32'h2074_6D66;
   localparam logic [31:0] ID_DATA = 32'h6174_6164;
   localparam logic [31:0] WAVE_WORD = 32'h4556_4157;

   localparam logic [15:0] FMT_PCM = 16'd1;
   localparam logic [15:0] MONO = 16'd1;

   localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_HEADER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

   localparam logic [ERR_W-1:0] ERR_NONE = 3'd0;
   localparam logic [ERR_W-1:0] ERR_NO_WAVE = 3'd1;
   localparam logic [ERR_W-1:0] ERR_BLOCK_ALIGN = 3'd2;
   localparam logic [ERR_W-1:0] ERR_NO_FMT = 3'd3;
   localparam logic [ERR_W-1:0] ERR_NOT_PCM = 3'd4;
   localparam logic [ERR_W-1:0] ERR_NOT_MONO = 3'd5;
   localparam logic [ERR_W-1:0] ERR_BAD_BITS = 3'd6;
   localparam logic [ERR_W-1:0] ERR_TRUNCATED = 3'd7;

   localparam logic [IDX_W-1:0] HDR_LAST_IDX = 5'd7;
   localparam logic [IDX_W-1:0] HDR_ID_BYTES = 5'd4;
   localparam logic [IDX_W-1:0] WAVE_LAST_IDX = 5'd3;
   localparam logic [IDX_W-1:0] FMT_LAST_IDX = 5'd15;

endpackage

### rtl/core/wav_pcm_stream_parser_core.sv
// Byte-serial RIFF/WAVE parser for mono PCM streams. One file byte is taken per
// req word (tlast on the final byte of the file) and at most one result word
// follows it: a header word when the data chunk opens, one Q1.31 sample word per
// complete 8, 16, 24 or 32 bit sample (tlast on the final sample), or a single
// error word. The parser state and the decode of each byte update in the cycle it
// is accepted, and the result is written into the output register at the same
// clock edge as that state. A new byte is accepted every cycle while that
// register is empty or being drained, so the sustained rate is one byte per clock.
// After the tlast byte all parser state returns to its reset values.
module wav_pcm_stream_parser_core
   import wpsp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // data_byte
   input  logic                  req_tlast,   // end_of_stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // sample[31:0], channel_count[47:32], rate_hz[79:48], sample_bits[95:80],
   // error_code[98:96], zero fill[103:99]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,   // last_sample
   output logic [KIND_W-1:0]     rsp_tuser    // kind
);

   typedef enum logic [3:0] {
      PH_HEADER,
      PH_WAVE,
      PH_FMT,
      PH_SKIP,
      PH_DATA,
      PH_DONE
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [IDX_W-1:0]   byte_index_ff, byte_index_in;
   logic [31:0]        field_shift_ff, field_shift_in;
   logic [31:0]        chunk_code_ff, chunk_code_in;
   logic [31:0]        bytes_left_ff, bytes_left_in;
   logic [15:0]        audio_format_ff, audio_format_in;
   logic [CHAN_W-1:0]  channels_ff, channels_in;
   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic [15:0]        align_ff, align_in;
   logic [BITS_W-1:0]  bits_ff, bits_in;
   logic [31:0]        gather_ff, gather_in;
   logic               error_latched_ff, error_latched_in;
   logic               fmt_done_ff, fmt_done_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;

   logic                  accept;
   logic [BYTE_W-1:0]     b;
   logic [IDX_W-1:0]      idx_inc;
   logic [2:0]            bps;
   logic [15:0]           b_lane;
   logic [31:0]           align_prod;
   logic                  res_valid;
   logic [KIND_W-1:0]     res_kind;
   logic [SAMPLE_W-1:0]   res_sample;
   logic                  res_last;
   logic [CHAN_W-1:0]     res_chan;
   logic [RATE_W-1:0]     res_rate;
   logic [BITS_W-1:0]     res_bits;
   logic [ERR_W-1:0]      res_err;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept = req_tvalid && req_tready;
   assign b = req_tdata;
   assign idx_inc = byte_index_ff + 5'd1;
   assign bps = bits_ff[5:3];
   assign b_lane = byte_index_ff[0] ? {b, 8'h00} : {8'h00, b};

   always_comb begin
      phase_in = phase_ff;
      byte_index_in = byte_index_ff;
      field_shift_in = field_shift_ff;
      chunk_code_in = chunk_code_ff;
      bytes_left_in = bytes_left_ff;
      audio_format_in = audio_format_ff;
      channels_in = channels_ff;
      rate_in = rate_ff;
      align_in = align_ff;
      bits_in = bits_ff;
      gather_in = gather_ff;
      error_latched_in = error_latched_ff;
      fmt_done_in = fmt_done_ff;
      align_prod = '0;
      res_valid = 1'b0;
      res_kind = KIND_SAMPLE;
      res_sample = '0;
      res_last = 1'b0;
      res_chan = '0;
      res_rate = '0;
      res_bits = '0;
      res_err = ERR_NONE;

      if (!error_latched_ff) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (byte_index_ff < HDR_ID_BYTES) begin
                  chunk_code_in = {b, chunk_code_ff[31:8]};
               end else begin
                  field_shift_in = {b, field_shift_ff[31:8]};
               end
               byte_index_in = idx_inc;
               if (byte_index_ff == HDR_LAST_IDX) begin
                  byte_index_in = '0;
                  if (chunk_code_ff == ID_RIFF) begin
                     phase_in = PH_WAVE;
                  end else if (chunk_code_ff == ID_FMT) begin
                     bytes_left_in = field_shift_in;
                     audio_format_in = '0;
                     channels_in = '0;
                     rate_in = '0;
                     align_in = '0;
                     bits_in = '0;
                     phase_in = PH_FMT;
                  end else if (chunk_code_ff == ID_DATA) begin
                     res_valid = 1'b1;
                     res_kind = KIND_ERROR;
                     if (!fmt_done_ff) begin
                        res_err = ERR_NO_FMT;
                     end else if (audio_format_ff != FMT_PCM) begin
                        res_err = ERR_NOT_PCM;
                     end else if (channels_ff != MONO) begin
                        res_err = ERR_NOT_MONO;
                     end else if (bits_ff != 16'd8 && bits_ff != 16'd16 &&
                                  bits_ff != 16'd24 && bits_ff != 16'd32) begin
                        res_err = ERR_BAD_BITS;
                     end
                     if (res_err != ERR_NONE) begin
                        error_latched_in = 1'b1;
                     end else begin
                        res_kind = KIND_HEADER;
                        res_chan = channels_ff;
                        res_rate = rate_ff;
                        res_bits = bits_ff;
                        bytes_left_in = field_shift_in;
                        gather_in = '0;
                        phase_in = (field_shift_in >= {29'd0, bps}) ? PH_DATA : PH_DONE;
                     end
                  end else begin
                     bytes_left_in = field_shift_in;
                     phase_in = (field_shift_in != '0) ? PH_SKIP : PH_HEADER;
                  end
               end
            end
            PH_WAVE: begin
               field_shift_in = {b, field_shift_ff[31:8]};
               byte_index_in = idx_inc;
               if (byte_index_ff == WAVE_LAST_IDX) begin
                  byte_index_in = '0;
                  if (field_shift_in != WAVE_WORD) begin
                     res_valid = 1'b1;
                     res_kind = KIND_ERROR;
                     res_err = ERR_NO_WAVE;
                     error_latched_in = 1'b1;
                  end else begin
                     phase_in = PH_HEADER;
                  end
               end
            end
            PH_FMT: begin
               if (bytes_left_ff != '0) bytes_left_in = bytes_left_ff - 32'd1;
               case (byte_index_ff) inside
                  5'd0, 5'd1: audio_format_in = audio_format_ff | b_lane;
                  5'd2, 5'd3: channels_in = channels_ff | b_lane;
                  5'd4, 5'd5, 5'd6, 5'd7:
                     rate_in = rate_ff | ({24'd0, b} << {byte_index_ff[1:0], 3'b000});
                  5'd12, 5'd13: align_in = align_ff | b_lane;
                  5'd14, 5'd15: bits_in = bits_ff | b_lane;
                  default: ;
               endcase
               byte_index_in = idx_inc;
               if (byte_index_ff == FMT_LAST_IDX) begin
                  byte_index_in = '0;
                  fmt_done_in = 1'b1;
                  align_prod = 32'(channels_ff) * 32'(bits_in);
                  if ({16'd0, align_ff} != {3'd0, align_prod[31:3]}) begin
                     res_valid = 1'b1;
                     res_kind = KIND_ERROR;
                     res_err = ERR_BLOCK_ALIGN;
                     error_latched_in = 1'b1;
                  end else begin
                     phase_in = (bytes_left_in != '0) ? PH_SKIP : PH_HEADER;
                  end
               end
            end
            PH_SKIP: begin
               if (bytes_left_ff != '0) bytes_left_in = bytes_left_ff - 32'd1;
               if (bytes_left_in == '0) phase_in = PH_HEADER;
            end
            PH_DATA: begin
               if (bytes_left_ff != '0) bytes_left_in = bytes_left_ff - 32'd1;
               gather_in = {b, gather_ff[31:8]};
               byte_index_in = idx_inc;
               if (idx_inc >= {2'd0, bps}) begin
                  res_valid = 1'b1;
                  res_kind = KIND_SAMPLE;
                  res_sample = gather_in ^ {(bps == 3'd1), 31'd0};
                  res_last = (bytes_left_in < {29'd0, bps}) || req_tlast;
                  byte_index_in = '0;
                  gather_in = '0;
                  if (res_last) phase_in = PH_DONE;
               end
            end
            PH_DONE: ;
            default: ;
         endcase
      end

      if (req_tlast) begin
         if (!res_valid && !error_latched_in && phase_in != PH_DONE) begin
            res_valid = 1'b1;
            res_kind = KIND_ERROR;
            res_err = ERR_TRUNCATED;
         end
         phase_in = PH_HEADER;
         byte_index_in = '0;
         field_shift_in = '0;
         chunk_code_in = '0;
         bytes_left_in = '0;
         audio_format_in = '0;
         channels_in = '0;
         rate_in = '0;
         align_in = '0;
         bits_in = '0;
         gather_in = '0;
         error_latched_in = 1'b0;
         fmt_done_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      rsp_kind_in = rsp_kind_ff;
      if (accept && res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = {(RSP_DATA_W - RSP_FIELDS_W)'(0), res_err, res_bits, res_rate,
                        res_chan, res_sample};
         rsp_last_in = res_last;
         rsp_kind_in = res_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         byte_index_ff <= '0;
         field_shift_ff <= '0;
         chunk_code_ff <= '0;
         bytes_left_ff <= '0;
         audio_format_ff <= '0;
         channels_ff <= '0;
         rate_ff <= '0;
         align_ff <= '0;
         bits_ff <= '0;
         gather_ff <= '0;
         error_latched_ff <= 1'b0;
         fmt_done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            byte_index_ff <= byte_index_in;
            field_shift_ff <= field_shift_in;
            chunk_code_ff <= chunk_code_in;
            bytes_left_ff <= bytes_left_in;
            audio_format_ff <= audio_format_in;
            channels_ff <= channels_in;
            rate_ff <= rate_in;
            align_ff <= align_in;
            bits_ff <= bits_in;
            gather_ff <= gather_in;
            error_latched_ff <= error_latched_in;
            fmt_done_ff <= fmt_done_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;
   assign rsp_tuser = rsp_kind_ff;

`ifndef NO_ASSERTIONS
   a_err_code_set: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_ERROR |-> rsp_tdata[98:96] != ERR_NONE)
      else $error("error word without error code");

   a_last_is_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == KIND_SAMPLE)
      else $error("last flag on a non-sample word");

   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> phase_ff == PH_HEADER && !error_latched_ff &&
                              byte_index_ff == '0 && !fmt_done_ff)
      else $error("parser state not cleared after end of stream");

   a_data_index: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> byte_index_ff < {2'd0, bps})
      else $error("sample byte index beyond sample width");

   a_no_data_after_error: assert property (@(posedge clock) disable iff (reset)
      error_latched_ff |-> phase_ff != PH_DATA)
      else $error("error latched while streaming samples");
`endif

endmodule
